@@ rtl/core/rthsv_pkg.sv @@
// Shared types, constants and helper functions for the RGB to HSV pixel converter.
`timescale 1ns / 1ps
`default_nettype none

package rthsv_pkg;

  typedef logic [7:0] chan_t;

  // Channel that holds the maximum, after tie-breaking.
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

  localparam int unsigned NUM_STAGES = 6;

  localparam int unsigned HUE_60  = 60;
  localparam int unsigned HUE_120 = 120;
  localparam int unsigned HUE_240 = 240;
  localparam int unsigned HUE_360 = 360;
  localparam int unsigned SAT_255 = 255;

  // floor(2^16 / d) reciprocal, dividend below 2^16, quotient below 256.
  localparam int unsigned RCP_ONE = 65536;
  localparam int unsigned RCP_W   = 17;

  // ceil(2^20 / 3): exact floor(y / 3) for y below 2^19.
  localparam logic [36:0] RCP3    = 37'd349526;

  // Finishes a reciprocal division: q0 is at most one below floor(x / d).
  function automatic chan_t div_fix(input logic [15:0] x, input chan_t q0,
                                    input chan_t d);
    logic [16:0] rem;
    logic        bump;
    rem  = {1'b0, x} - ({9'b0, q0} * {9'b0, d});
    bump = (rem >= {9'b0, d});
    if (d == '0) begin
      return '0;
    end
    return q0 + {7'b0, bump};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rthsv_if.sv @@
// Valid/ready channel interfaces for pixels in and HSV results out.
`timescale 1ns / 1ps
`default_nettype none

interface rthsv_in_if;
  logic                 valid;
  logic                 ready;
  rthsv_pkg::chan_t     blue_in;
  rthsv_pkg::chan_t     green_in;
  rthsv_pkg::chan_t     red_in;

  modport source (output valid, output blue_in, output green_in, output red_in,
                  input ready);
  modport sink   (input valid, input blue_in, input green_in, input red_in,
                  output ready);
endinterface

interface rthsv_out_if;
  logic                 valid;
  logic                 ready;
  rthsv_pkg::chan_t     hue_scaled;
  rthsv_pkg::chan_t     hue_half;
  rthsv_pkg::chan_t     saturation;
  rthsv_pkg::chan_t     value_out;

  modport source (output valid, output hue_scaled, output hue_half,
                  output saturation, output value_out, input ready);
  modport sink   (input valid, input hue_scaled, input hue_half,
                  input saturation, input value_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rgb_to_hsv_pixel_top.sv @@
// Pipelined 8-bit BGR to HSV pixel converter.
//
//   channel   dir   handshake                 payload
//   in_pix    in    valid/ready (sink)        blue_in, green_in, red_in
//   out_pix   out   valid/ready (source)      hue_scaled, hue_half, saturation, value_out
//
// One pixel per cycle sustained while out_pix.ready stays high.
// The three divisions use a 256-entry reciprocal table, a multiply and a one-step fixup,
// spread over the six stages together with the hue numerator and the 17/24 scaling.
// Reset (rst_n low, synchronous) clears every stage valid bit.
// A full stage holds while the stage after it is full and stalled; bubbles close up.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_pixel_top (
  input  wire logic      clk,
  input  wire logic      rst_n,
  rthsv_in_if.sink       in_pix,
  rthsv_out_if.source    out_pix
);

  localparam int unsigned NS = rthsv_pkg::NUM_STAGES;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  // reciprocal table, entry 0 unused (grey and black handled by div_fix)
  logic [rthsv_pkg::RCP_W-1:0] rcp_tbl [256];

  assign rcp_tbl[0] = '0;
  for (genvar i = 1; i < 256; i++) begin : g_rcp
    localparam logic [rthsv_pkg::RCP_W-1:0] RV = rthsv_pkg::RCP_W'(rthsv_pkg::RCP_ONE / i);
    assign rcp_tbl[i] = RV;
  end

  // stall chain
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_pix.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_pix.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_pix.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: max, min, chroma, difference
  rthsv_pkg::chan_t     s1_mx_nxt, s1_mn_nxt, s1_c_nxt;
  rthsv_pkg::max_sel_t  s1_sel_nxt;
  logic signed [8:0]    s1_d_nxt;
  rthsv_pkg::chan_t     s1_mx_r, s1_c_r;
  rthsv_pkg::max_sel_t  s1_sel_r;
  logic signed [8:0]    s1_d_r;

  always_comb begin
    rthsv_pkg::chan_t b, g, r;
    b = in_pix.blue_in;
    g = in_pix.green_in;
    r = in_pix.red_in;
    s1_mx_nxt = r;
    if (g > s1_mx_nxt) s1_mx_nxt = g;
    if (b > s1_mx_nxt) s1_mx_nxt = b;
    s1_mn_nxt = r;
    if (g < s1_mn_nxt) s1_mn_nxt = g;
    if (b < s1_mn_nxt) s1_mn_nxt = b;
    s1_c_nxt = s1_mx_nxt - s1_mn_nxt;
    priority if (b == s1_mx_nxt) begin
      s1_sel_nxt = rthsv_pkg::SEL_BLUE;
      s1_d_nxt   = $signed({1'b0, r}) - $signed({1'b0, g});
    end else if (g == s1_mx_nxt) begin
      s1_sel_nxt = rthsv_pkg::SEL_GREEN;
      s1_d_nxt   = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      s1_sel_nxt = rthsv_pkg::SEL_RED;
      s1_d_nxt   = $signed({1'b0, g}) - $signed({1'b0, b});
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_mx_r  <= s1_mx_nxt;
      s1_c_r   <= s1_c_nxt;
      s1_sel_r <= s1_sel_nxt;
      s1_d_r   <= s1_d_nxt;
    end
  end

  // ---------------- stage 2: hue numerator, reciprocal lookups
  logic [16:0]                 s2_hn_nxt;
  logic [15:0]                 s2_xs_nxt;
  logic [16:0]                 s2_hn_r;
  logic [15:0]                 s2_xs_r;
  logic [rthsv_pkg::RCP_W-1:0] s2_rc_r, s2_rm_r;
  rthsv_pkg::chan_t            s2_mx_r, s2_c_r;

  always_comb begin
    logic [16:0]        base;
    logic [16:0]        c360;
    logic signed [18:0] d_ext;
    logic signed [18:0] hn_raw;
    unique case (s1_sel_r)
      rthsv_pkg::SEL_BLUE:  base = {9'b0, s1_c_r} * 17'(rthsv_pkg::HUE_240);
      rthsv_pkg::SEL_GREEN: base = {9'b0, s1_c_r} * 17'(rthsv_pkg::HUE_120);
      rthsv_pkg::SEL_RED:   base = '0;
      default:              base = '0;
    endcase
    c360   = {9'b0, s1_c_r} * 17'(rthsv_pkg::HUE_360);
    d_ext  = {{10{s1_d_r[8]}}, s1_d_r};
    hn_raw = $signed({2'b00, base}) + d_ext * $signed(19'(rthsv_pkg::HUE_60));
    if (hn_raw[18]) begin
      hn_raw = hn_raw + $signed({2'b00, c360});
    end
    s2_hn_nxt = hn_raw[16:0];
    s2_xs_nxt = {8'b0, s1_c_r} * 16'(rthsv_pkg::SAT_255);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_hn_r <= s2_hn_nxt;
      s2_xs_r <= s2_xs_nxt;
      s2_rc_r <= rcp_tbl[s1_c_r];
      s2_rm_r <= rcp_tbl[s1_mx_r];
      s2_mx_r <= s1_mx_r;
      s2_c_r  <= s1_c_r;
    end
  end

  // ---------------- stage 3: hue scaling prep, saturation estimate
  logic [17:0]                 s3_y_nxt;
  logic [32:0]                 s3_ps_nxt;
  logic [17:0]                 s3_y_r;
  logic [15:0]                 s3_x1_r;
  rthsv_pkg::chan_t            s3_q0s_r;
  logic [15:0]                 s3_xs_r;
  logic [rthsv_pkg::RCP_W-1:0] s3_rc_r;
  rthsv_pkg::chan_t            s3_mx_r, s3_c_r;

  always_comb begin
    logic [20:0] hn17;
    hn17      = ({4'b0, s2_hn_r} << 4) + {4'b0, s2_hn_r};
    s3_y_nxt  = hn17[20:3];
    s3_ps_nxt = {17'b0, s2_xs_r} * {16'b0, s2_rm_r};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_y_r   <= s3_y_nxt;
      s3_x1_r  <= s2_hn_r[16:1];
      s3_q0s_r <= s3_ps_nxt[23:16];
      s3_xs_r  <= s2_xs_r;
      s3_rc_r  <= s2_rc_r;
      s3_mx_r  <= s2_mx_r;
      s3_c_r   <= s2_c_r;
    end
  end

  // ---------------- stage 4: divide by 3, half-hue estimate, saturation fixup
  logic [36:0]                 s4_p3_nxt;
  logic [32:0]                 s4_p1_nxt;
  logic [15:0]                 s4_x2_r;
  logic [15:0]                 s4_x1_r;
  rthsv_pkg::chan_t            s4_q01_r;
  rthsv_pkg::chan_t            s4_sat_r;
  logic [rthsv_pkg::RCP_W-1:0] s4_rc_r;
  rthsv_pkg::chan_t            s4_mx_r, s4_c_r;

  assign s4_p3_nxt = {19'b0, s3_y_r} * rthsv_pkg::RCP3;
  assign s4_p1_nxt = {17'b0, s3_x1_r} * {16'b0, s3_rc_r};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_x2_r  <= s4_p3_nxt[35:20];
      s4_x1_r  <= s3_x1_r;
      s4_q01_r <= s4_p1_nxt[23:16];
      s4_sat_r <= rthsv_pkg::div_fix(s3_xs_r, s3_q0s_r, s3_mx_r);
      s4_rc_r  <= s3_rc_r;
      s4_mx_r  <= s3_mx_r;
      s4_c_r   <= s3_c_r;
    end
  end

  // ---------------- stage 5: half-hue fixup, scaled-hue estimate
  logic [32:0]      s5_p2_nxt;
  logic [15:0]      s5_x2_r;
  rthsv_pkg::chan_t s5_q02_r;
  rthsv_pkg::chan_t s5_hh_r;
  rthsv_pkg::chan_t s5_sat_r;
  rthsv_pkg::chan_t s5_mx_r, s5_c_r;

  assign s5_p2_nxt = {17'b0, s4_x2_r} * {16'b0, s4_rc_r};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_x2_r  <= s4_x2_r;
      s5_q02_r <= s5_p2_nxt[23:16];
      s5_hh_r  <= rthsv_pkg::div_fix(s4_x1_r, s4_q01_r, s4_c_r);
      s5_sat_r <= s4_sat_r;
      s5_mx_r  <= s4_mx_r;
      s5_c_r   <= s4_c_r;
    end
  end

  // ---------------- stage 6: scaled-hue fixup, output register
  rthsv_pkg::chan_t s6_hs_r, s6_hh_r, s6_sat_r, s6_mx_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_hs_r  <= rthsv_pkg::div_fix(s5_x2_r, s5_q02_r, s5_c_r);
      s6_hh_r  <= s5_hh_r;
      s6_sat_r <= s5_sat_r;
      s6_mx_r  <= s5_mx_r;
    end
  end

  assign out_pix.valid      = vld_r[NS-1];
  assign out_pix.hue_scaled = s6_hs_r;
  assign out_pix.hue_half   = s6_hh_r;
  assign out_pix.saturation = s6_sat_r;
  assign out_pix.value_out  = s6_mx_r;

`ifndef SYNTHESIS
  // grey pixels carry zero hue
  a_grey_hue : assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid && (out_pix.saturation == '0) |->
      (out_pix.hue_scaled == '0) && (out_pix.hue_half == '0))
    else $error("nonzero hue on a grey pixel");

  // hue stays within its scales
  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid |-> (out_pix.hue_half <= 8'd179) && (out_pix.hue_scaled <= 8'd254))
    else $error("hue out of range");

  // a full stage 4 that is held keeps its item
  a_stage_hold : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !en[3] |=> vld_r[3] && $stable(s4_x2_r) && $stable(s4_sat_r))
    else $error("stalled stage lost or changed its item");

  // an empty first stage never blocks the input
  a_bubble_fill : assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_pix.ready)
    else $error("input blocked while first stage is empty");
`endif

endmodule

`default_nettype wire

@@ bench/tb_rgb_to_hsv_pixel_top.sv @@
// Self-checking bench for the pipelined BGR to HSV pixel converter with random handshake gaps.
`timescale 1ns / 1ps

typedef struct packed {
  rthsv_pkg::chan_t hue_scaled;
  rthsv_pkg::chan_t hue_half;
  rthsv_pkg::chan_t saturation;
  rthsv_pkg::chan_t value_out;
} hsv_pix_t;

class hsv_scoreboard;
  hsv_pix_t hsv_expected_q[$];
  int       mismatches;

  function new();
    mismatches = 0;
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Exact integer HSV, truncated; ties go blue, then green, then red.
  function hsv_pix_t convert_pixel(rthsv_pkg::chan_t b, rthsv_pkg::chan_t g,
                                   rthsv_pkg::chan_t r);
    int       bi;
    int       gi;
    int       ri;
    int       mx;
    int       mn;
    int       chroma;
    int       hnum;
    hsv_pix_t p;
    bi = int'(b);
    gi = int'(g);
    ri = int'(r);
    mx = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    mn = ri;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    chroma = mx - mn;
    p = '0;
    p.value_out = 8'(mx);
    if (mx != 0) begin
      p.saturation = 8'((255 * chroma) / mx);
    end
    if (chroma != 0) begin
      if (bi == mx) begin
        hnum = 240 * chroma + 60 * (ri - gi);
      end else if (gi == mx) begin
        hnum = 120 * chroma + 60 * (bi - ri);
      end else begin
        hnum = 60 * (gi - bi);
        if (hnum < 0) hnum += 360 * chroma;
      end
      p.hue_scaled = 8'((hnum * 255) / (360 * chroma));
      p.hue_half   = 8'(hnum / (2 * chroma));
    end
    return p;
  endfunction

  function void note_pixel(rthsv_pkg::chan_t b, rthsv_pkg::chan_t g, rthsv_pkg::chan_t r);
    hsv_expected_q = {hsv_expected_q, convert_pixel(b, g, r)};
  endfunction

  task check_result(hsv_pix_t got);
    hsv_pix_t exp_pix;
    if (hsv_expected_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: %h", got));
      return;
    end
    exp_pix = hsv_expected_q.pop_front();
    if (got.hue_scaled != exp_pix.hue_scaled)
      report_mismatch($sformatf("hue_scaled got %0d exp %0d", got.hue_scaled,
                                exp_pix.hue_scaled));
    if (got.hue_half != exp_pix.hue_half)
      report_mismatch($sformatf("hue_half got %0d exp %0d", got.hue_half,
                                exp_pix.hue_half));
    if (got.saturation != exp_pix.saturation)
      report_mismatch($sformatf("saturation got %0d exp %0d", got.saturation,
                                exp_pix.saturation));
    if (got.value_out != exp_pix.value_out)
      report_mismatch($sformatf("value_out got %0d exp %0d", got.value_out,
                                exp_pix.value_out));
  endtask

  function int pending();
    return hsv_expected_q.size();
  endfunction
endclass

module tb_rgb_to_hsv_pixel_top;

  localparam int RANDOM_PIXELS = 850;
  localparam int DRAIN_LIMIT   = 4000;

  logic clk;
  logic rst_n;

  rthsv_in_if  in_pix ();
  rthsv_out_if out_pix ();

  hsv_scoreboard sb;

  rgb_to_hsv_pixel_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (in_pix),
    .out_pix(out_pix)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // 0: no idling, 1: full 0..16 spread, 2: occasional gaps
  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 16);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  task automatic send_pixel(rthsv_pkg::chan_t b, rthsv_pkg::chan_t g, rthsv_pkg::chan_t r,
                            int gap);
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pix.valid    <= 1'b1;
    in_pix.blue_in  <= b;
    in_pix.green_in <= g;
    in_pix.red_in   <= r;
    do @(posedge clk); while (!in_pix.ready);
    sb.note_pixel(b, g, r);
    @(negedge clk);
  endtask

  task automatic collect_results();
    int       stall;
    int       mode;
    int       count;
    hsv_pix_t got;
    mode  = 1;
    count = 0;
    forever begin
      if (count % 48 == 0) mode = $urandom_range(0, 2);
      stall = draw_gap(mode);
      if (stall > 0) begin
        out_pix.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_pix.ready <= 1'b1;
      do @(posedge clk); while (!out_pix.valid);
      got.hue_scaled = out_pix.hue_scaled;
      got.hue_half   = out_pix.hue_half;
      got.saturation = out_pix.saturation;
      got.value_out  = out_pix.value_out;
      sb.check_result(got);
      count++;
      @(negedge clk);
    end
  endtask

  task automatic random_pixel(output rthsv_pkg::chan_t b, output rthsv_pkg::chan_t g,
                              output rthsv_pkg::chan_t r);
    int               kind;
    int               base;
    rthsv_pkg::chan_t hi;
    rthsv_pkg::chan_t lo;
    kind = $urandom_range(0, 9);
    b = 8'($urandom);
    g = 8'($urandom);
    r = 8'($urandom);
    case (kind)
      0: begin
        g = b;
        r = b;
      end
      1: begin
        hi = 8'($urandom_range(1, 255));
        lo = 8'($urandom_range(0, int'(hi) - 1));
        case ($urandom_range(0, 2))
          0: begin b = hi; g = hi; r = lo; end
          1: begin g = hi; r = hi; b = lo; end
          default: begin b = hi; r = hi; g = lo; end
        endcase
      end
      2: begin
        b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
        g = ($urandom_range(0, 1) == 0) ? 8'h01 : 8'hfe;
        r = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
        if ($urandom_range(0, 1) == 0) begin
          hi = b; b = g; g = hi;
        end
      end
      3: begin
        base = $urandom_range(2, 253);
        b = 8'(base + $urandom_range(0, 2) - 1);
        g = 8'(base + $urandom_range(0, 2) - 1);
        r = 8'(base + $urandom_range(0, 2) - 1);
      end
      default: ;
    endcase
  endtask

  task automatic run_directed();
    send_pixel(8'd0,   8'd0,   8'd0,   0);  // black
    send_pixel(8'd255, 8'd255, 8'd255, 0);  // white
    send_pixel(8'd128, 8'd128, 8'd128, 1);  // grey
    send_pixel(8'd0,   8'd0,   8'd255, 0);  // pure red
    send_pixel(8'd0,   8'd255, 8'd0,   0);  // pure green
    send_pixel(8'd255, 8'd0,   8'd0,   2);  // pure blue
    send_pixel(8'd100, 8'd50,  8'd200, 0);  // red max, green below blue
    send_pixel(8'd254, 8'd0,   8'd255, 0);  // negative hue near wrap
    send_pixel(8'd50,  8'd100, 8'd200, 0);  // red max, green above blue
    send_pixel(8'd200, 8'd200, 8'd10,  0);  // blue/green tie
    send_pixel(8'd10,  8'd200, 8'd200, 3);  // green/red tie
    send_pixel(8'd200, 8'd10,  8'd200, 0);  // blue/red tie
    send_pixel(8'd0,   8'd0,   8'd1,   0);  // smallest nonzero max
    send_pixel(8'd255, 8'd254, 8'd255, 0);  // chroma one, tie
    send_pixel(8'd1,   8'd255, 8'd0,   0);
    send_pixel(8'd255, 8'd1,   8'd0,   0);
    send_pixel(8'd0,   8'd255, 8'd255, 0);
    send_pixel(8'd255, 8'd0,   8'd255, 0);
    send_pixel(8'd255, 8'd255, 8'd0,   0);
    send_pixel(8'd170, 8'd85,  8'd255, 5);
    send_pixel(8'd85,  8'd255, 8'd170, 0);
    send_pixel(8'd255, 8'd170, 8'd85,  0);
  endtask

  task automatic run_random();
    rthsv_pkg::chan_t b;
    rthsv_pkg::chan_t g;
    rthsv_pkg::chan_t r;
    int               mode;
    mode = 0;
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 64 == 0) mode = $urandom_range(0, 2);
      random_pixel(b, g, r);
      send_pixel(b, g, r, draw_gap(mode));
    end
    in_pix.valid <= 1'b0;
  endtask

  initial begin
    int waited;
    sb = new();
    rst_n            <= 1'b0;
    in_pix.valid     <= 1'b0;
    in_pix.blue_in   <= '0;
    in_pix.green_in  <= '0;
    in_pix.red_in    <= '0;
    out_pix.ready    <= 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    fork
      collect_results();
    join_none
    run_directed();
    run_random();
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (3 * rthsv_pkg::NUM_STAGES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rthsv_pkg.sv
rtl/core/rthsv_if.sv
rtl/core/rgb_to_hsv_pixel_top.sv
bench/tb_rgb_to_hsv_pixel_top.sv
